// ----- src/vcl_pkg.sv -----
// Shared types, constants and lookup tables for the velocity compressor/limiter.
package vcl_pkg;

  localparam int TRACK_W     = 8;
  localparam int VEL_W       = 7;
  localparam int SET_W       = 33;
  localparam int REG_COUNT   = 4;
  localparam int CFG_INDEX_W = 3;

  // disabled, threshold 80, 4:1, gain 0, hard knee, min 1, max 127
  localparam logic [SET_W-1:0] SETTINGS_RESET = 33'h1_FC08_03A0;

  // settings field positions
  localparam int F_EN_BIT   = 0;
  localparam int F_THR_LSB  = 1;
  localparam int F_RAT_LSB  = 8;
  localparam int F_GAIN_LSB = 11;
  localparam int F_KNEE_BIT = 18;
  localparam int F_MIN_LSB  = 19;
  localparam int F_MAX_LSB  = 26;

  localparam logic signed [6:0] GAIN_MIN = -7'sd20;
  localparam logic signed [6:0] GAIN_MAX = 7'sd40;

  // half of the 12-unit soft knee
  localparam logic [VEL_W-1:0] KNEE_HALF = 7'd6;

  // widths of the divider operands
  localparam int KP_W = 10;  // (d+6)^2*d, d in 1..5
  localparam int RM_W = 10;  // ratio - 1
  localparam int A_W  = 20;  // dividend integer part
  localparam int E_W  = 19;  // doubled divisor
  localparam int C_W  = 18;  // rounding addend

  localparam int DIV_STEP  = 8;  // quotient bits per divider stage
  localparam int QUO_INT_W = 7;  // integer bits of the quotient

  typedef struct packed {
    logic                    bypass;
    logic                    sub_mode;  // 1: C = base - Q, 0: C = base + Q
    logic [VEL_W-1:0]        vel_raw;
    logic [VEL_W-1:0]        base;
    logic [VEL_W-1:0]        d;
    logic signed [6:0]       gain;
    logic [VEL_W-1:0]        vmin;
    logic [VEL_W-1:0]        vmax;
  } item_t;

  typedef struct packed {
    item_t           side;
    logic [A_W-1:0]  a;
    logic [E_W-1:0]  e;
    logic [C_W-1:0]  c;
  } div_req_t;

  function automatic logic [VEL_W-1:0] clamp_low1(input logic [VEL_W-1:0] x);
    return (x == '0) ? VEL_W'(1) : x;
  endfunction

  function automatic logic [RM_W-1:0] ratio_m1(input logic [2:0] idx);
    logic [RM_W-1:0] r;
    case (idx)
      3'd0: r = 10'd0;
      3'd1: r = 10'd1;
      3'd2: r = 10'd2;
      3'd3: r = 10'd3;
      3'd4: r = 10'd5;
      3'd5: r = 10'd7;
      3'd6: r = 10'd9;
      3'd7: r = 10'd999;
    endcase
    return r;
  endfunction

  // hard knee: divisor 2r, addend r
  function automatic logic [E_W-1:0] den_hard(input logic [2:0] idx);
    logic [E_W-1:0] r;
    case (idx)
      3'd0: r = 19'd2;
      3'd1: r = 19'd4;
      3'd2: r = 19'd6;
      3'd3: r = 19'd8;
      3'd4: r = 19'd12;
      3'd5: r = 19'd16;
      3'd6: r = 19'd20;
      3'd7: r = 19'd2000;
    endcase
    return r;
  endfunction

  function automatic logic [C_W-1:0] add_hard(input logic [2:0] idx);
    logic [C_W-1:0] r;
    case (idx)
      3'd0: r = 18'd1;
      3'd1: r = 18'd2;
      3'd2: r = 18'd3;
      3'd3: r = 18'd4;
      3'd4: r = 18'd6;
      3'd5: r = 18'd8;
      3'd6: r = 18'd10;
      3'd7: r = 18'd1000;
    endcase
    return r;
  endfunction

  // soft knee: divisor 288r, addend 144r - 1
  function automatic logic [E_W-1:0] den_knee(input logic [2:0] idx);
    logic [E_W-1:0] r;
    case (idx)
      3'd0: r = 19'd288;
      3'd1: r = 19'd576;
      3'd2: r = 19'd864;
      3'd3: r = 19'd1152;
      3'd4: r = 19'd1728;
      3'd5: r = 19'd2304;
      3'd6: r = 19'd2880;
      3'd7: r = 19'd288000;
    endcase
    return r;
  endfunction

  function automatic logic [C_W-1:0] add_knee(input logic [2:0] idx);
    logic [C_W-1:0] r;
    case (idx)
      3'd0: r = 18'd143;
      3'd1: r = 18'd287;
      3'd2: r = 18'd431;
      3'd3: r = 18'd575;
      3'd4: r = 18'd863;
      3'd5: r = 18'd1151;
      3'd6: r = 18'd1439;
      3'd7: r = 18'd143999;
    endcase
    return r;
  endfunction

  // (d+6)^2 * d inside the knee
  function automatic logic [KP_W-1:0] knee_poly(input logic [2:0] d);
    logic [KP_W-1:0] r;
    case (d)
      3'd1:    r = 10'd49;
      3'd2:    r = 10'd128;
      3'd3:    r = 10'd243;
      3'd4:    r = 10'd400;
      3'd5:    r = 10'd605;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/vcl_in_if.sv -----
// Input word channel: track number and note velocity.
interface vcl_in_if import vcl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] track;
  logic [VEL_W-1:0]   velocity;

  modport source (output valid, output track, output velocity, input ready);
  modport sink   (input valid, input track, input velocity, output ready);
endinterface

// ----- src/vcl_out_if.sv -----
// Output word channel: compressed velocity and gain reduction.
interface vcl_out_if import vcl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VEL_W-1:0] velocity_out;
  logic [VEL_W-1:0] gain_reduction;

  modport source (output valid, output velocity_out, output gain_reduction, input ready);
  modport sink   (input valid, input velocity_out, input gain_reduction, output ready);
endinterface

// ----- src/vcl_decode.sv -----
// Settings registers, field decode and knee product: first two pipeline stages.
module vcl_decode import vcl_pkg::*; #(
  parameter int TRACK_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]       cfg_data,
  input  logic [1:0]             en,
  input  logic [TRACK_W-1:0]     track,
  input  logic [VEL_W-1:0]       velocity,
  output div_req_t               req
);

  // tracks past the register file never read a register
  localparam int ACTIVE = (TRACK_COUNT < REG_COUNT) ? TRACK_COUNT : REG_COUNT;

  logic [SET_W-1:0] settings [ACTIVE];

  always_ff @(posedge clk) begin
    for (int i = 0; i < ACTIVE; i++) begin
      if (rst) begin
        settings[i] <= SETTINGS_RESET;
      end else if (cfg_we && cfg_index == CFG_INDEX_W'(i)) begin
        settings[i] <= cfg_data;
      end
    end
  end

  // stage 1: field decode
  logic [SET_W-1:0]  s_sel;
  logic              hit;
  logic [VEL_W-1:0]  thr, vv, dd, gmn, gmx;
  logic signed [6:0] graw, gcl;
  logic              above, knee;

  always_comb begin
    s_sel = '0;
    hit   = 1'b0;
    for (int i = 0; i < ACTIVE; i++) begin
      if (track == TRACK_W'(i)) begin
        s_sel = settings[i];
        hit   = 1'b1;
      end
    end
    thr  = clamp_low1(s_sel[F_THR_LSB +: VEL_W]);
    gmn  = clamp_low1(s_sel[F_MIN_LSB +: VEL_W]);
    gmx  = clamp_low1(s_sel[F_MAX_LSB +: VEL_W]);
    graw = $signed(s_sel[F_GAIN_LSB +: 7]);
    if (graw < GAIN_MIN) begin
      gcl = GAIN_MIN;
    end else if (graw > GAIN_MAX) begin
      gcl = GAIN_MAX;
    end else begin
      gcl = graw;
    end
    vv    = clamp_low1(velocity);
    above = vv > thr;
    dd    = vv - thr;
    knee  = s_sel[F_KNEE_BIT] && above && (dd < KNEE_HALF);
  end

  logic              s1_bypass, s1_above, s1_knee;
  logic [VEL_W-1:0]  s1_vel_raw, s1_v, s1_t, s1_d, s1_vmin, s1_vmax;
  logic signed [6:0] s1_gain;
  logic [KP_W-1:0]   s1_kpoly;
  logic [2:0]        s1_ridx;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_bypass  <= !(hit && s_sel[F_EN_BIT]);
      s1_above   <= above;
      s1_knee    <= knee;
      s1_vel_raw <= velocity;
      s1_v       <= vv;
      s1_t       <= thr;
      s1_d       <= dd;
      s1_vmin    <= gmn;
      s1_vmax    <= gmx;
      s1_gain    <= gcl;
      s1_kpoly   <= knee_poly(dd[2:0]);
      s1_ridx    <= s_sel[F_RAT_LSB +: 3];
    end
  end

  // stage 2: knee product and divider operands
  logic [A_W-1:0] x;
  div_req_t       req_next;

  always_comb begin
    x = A_W'(s1_kpoly) * A_W'(ratio_m1(s1_ridx));
    req_next.side.bypass   = s1_bypass;
    req_next.side.sub_mode = !s1_above || s1_knee;
    req_next.side.vel_raw  = s1_vel_raw;
    req_next.side.base     = (!s1_above || s1_knee) ? s1_v : s1_t;
    req_next.side.d        = s1_d;
    req_next.side.gain     = s1_gain;
    req_next.side.vmin     = s1_vmin;
    req_next.side.vmax     = s1_vmax;
    if (!s1_above) begin
      // at or below threshold: zero quotient
      req_next.a = '0;
      req_next.e = den_hard(3'd0);
      req_next.c = '0;
    end else if (s1_knee) begin
      req_next.a = x;
      req_next.e = den_knee(s1_ridx);
      req_next.c = add_knee(s1_ridx);
    end else begin
      req_next.a = A_W'(s1_d);
      req_next.e = den_hard(s1_ridx);
      req_next.c = add_hard(s1_ridx);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      req <= req_next;
    end
  end

endmodule

// ----- src/vcl_divider.sv -----
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
module vcl_divider import vcl_pkg::*; #(
  parameter  int FRAC_BITS = 16,
  localparam int QW = FRAC_BITS + QUO_INT_W,
  localparam int DS = (QW + DIV_STEP - 1) / DIV_STEP
) (
  input  logic          clk,
  input  logic [DS-1:0] en,
  input  div_req_t      req,
  output logic [QW-1:0] quo,
  output item_t         side
);

  localparam int ZW = FRAC_BITS + A_W + 2;
  localparam int RW = E_W;

  // dividend (a << (F+1)) + c; quotient fits QW bits
  logic [ZW-1:0] z;
  assign z = ZW'({req.a, {(FRAC_BITS + 1){1'b0}}}) + ZW'(req.c);

  item_t          side_in [DS];
  logic [RW-1:0]  rem_in  [DS];
  logic [QW-1:0]  zlo_in  [DS];
  logic [QW-1:0]  quo_in  [DS];
  logic [E_W-1:0] den_in  [DS];

  item_t          side_q [DS];
  logic [QW-1:0]  quo_q  [DS];
  logic [RW-1:0]  rem_q  [DS-1];
  logic [QW-1:0]  zlo_q  [DS-1];
  logic [E_W-1:0] den_q  [DS-1];

  assign side_in[0] = req.side;
  assign rem_in[0]  = RW'(z[ZW-1:QW]);
  assign zlo_in[0]  = z[QW-1:0];
  assign quo_in[0]  = '0;
  assign den_in[0]  = req.e;

  for (genvar s = 0; s < DS; s++) begin : g_stage
    localparam int FIRST = s * DIV_STEP;
    localparam int NSTEP = (QW - FIRST < DIV_STEP) ? (QW - FIRST) : DIV_STEP;

    logic [RW-1:0] rem_n;
    logic [QW-1:0] quo_n;

    if (s > 0) begin : g_link
      assign side_in[s] = side_q[s-1];
      assign rem_in[s]  = rem_q[s-1];
      assign zlo_in[s]  = zlo_q[s-1];
      assign quo_in[s]  = quo_q[s-1];
      assign den_in[s]  = den_q[s-1];
    end

    always_comb begin
      logic [RW:0] acc;
      rem_n = rem_in[s];
      quo_n = quo_in[s];
      acc   = '0;
      for (int k = 0; k < NSTEP; k++) begin
        acc = {rem_n, zlo_in[s][QW-1-FIRST-k]};
        if (acc >= {1'b0, den_in[s]}) begin
          acc = acc - {1'b0, den_in[s]};
          quo_n[QW-1-FIRST-k] = 1'b1;
        end
        rem_n = acc[RW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        side_q[s] <= side_in[s];
        quo_q[s]  <= quo_n;
      end
    end

    if (s < DS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[s]) begin
          rem_q[s] <= rem_n;
          zlo_q[s] <= zlo_in[s];
          den_q[s] <= den_in[s];
        end
      end
    end
  end

  assign quo  = quo_q[DS-1];
  assign side = side_q[DS-1];

endmodule

// ----- src/vcl_finish.sv -----
// Makeup gain, rounding, caps and gain reduction: last two pipeline stages.
module vcl_finish import vcl_pkg::*; #(
  parameter  int FRAC_BITS = 16,
  localparam int QW = FRAC_BITS + QUO_INT_W
) (
  input  logic             clk,
  input  logic [1:0]       en,
  input  logic [QW-1:0]    quo,
  input  item_t            side,
  output logic [VEL_W-1:0] velocity_out,
  output logic [VEL_W-1:0] gain_reduction
);

  localparam int SW = FRAC_BITS + 10;
  localparam int LW = FRAC_BITS + 7;
  localparam logic [LW:0] HALF = (LW + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [LW-1:0] TOP = {7'h7F, {FRAC_BITS{1'b0}}};

  // stage 1: level plus gain, reduction in fixed point
  logic signed [8:0] bg;
  logic [SW-1:0]     bg_ext, q_ext, sum_n;
  logic [LW-1:0]     red_n;

  always_comb begin
    bg     = $signed({2'b00, side.base}) + $signed({{2{side.gain[6]}}, side.gain});
    bg_ext = {bg[8], bg, {FRAC_BITS{1'b0}}};
    q_ext  = {3'b000, quo};
    sum_n  = side.sub_mode ? (bg_ext - q_ext) : (bg_ext + q_ext);
    red_n  = side.sub_mode ? quo : ({side.d, {FRAC_BITS{1'b0}}} - quo);
  end

  logic [SW-1:0]    p1_sum;
  logic [LW-1:0]    p1_red;
  logic             p1_bypass;
  logic [VEL_W-1:0] p1_vel_raw, p1_vmin, p1_vmax;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1_sum     <= sum_n;
      p1_red     <= red_n;
      p1_bypass  <= side.bypass;
      p1_vel_raw <= side.vel_raw;
      p1_vmin    <= side.vmin;
      p1_vmax    <= side.vmax;
    end
  end

  // stage 2: clamp, round, caps
  logic [LW-1:0]    sc;
  logic [LW:0]      vr, rr;
  logic [VEL_W-1:0] iv, vel_n, red_o;

  always_comb begin
    if (p1_sum[SW-1]) begin
      sc = '0;
    end else if (p1_sum[SW-2:LW] != '0 || p1_sum[LW-1:0] > TOP) begin
      sc = TOP;
    end else begin
      sc = p1_sum[LW-1:0];
    end
    vr = {1'b0, sc} + HALF;
    iv = clamp_low1(vr[LW-1:FRAC_BITS]);
    if (iv < p1_vmin) begin
      iv = p1_vmin;
    end
    if (iv > p1_vmax) begin
      iv = p1_vmax;
    end
    rr = {1'b0, p1_red} + HALF;
    if (p1_bypass) begin
      vel_n = p1_vel_raw;
      red_o = '0;
    end else begin
      vel_n = iv;
      red_o = rr[LW-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      velocity_out   <= vel_n;
      gain_reduction <= red_o;
    end
  end

endmodule

// ----- src/velocity_compressor_limiter.sv -----
// Top level of the per-track velocity compressor/limiter pipeline.
//
// Use: a word on the sample channel carries a track number and a 7-bit note
// velocity; one word comes back on the result channel for every word taken,
// in order: the compressed, gain-adjusted, capped velocity and the number of
// velocity units removed by compression. Disabled or unknown tracks pass the
// velocity through with zero reduction.
// Settings: four 33-bit registers, one per track, written through cfg_we /
// cfg_index / cfg_data only while the pipe is empty, which the user must
// ensure as the block does not enforce it; indexes past 3 are dropped.
// Throughput: one word per cycle while result.ready stays high.
// Pipeline: (FRAC_BITS+7)/8 rounded up plus 4 register stages, 7 at
// FRAC_BITS = 16: decode, knee product, one divider stage per 8 quotient
// bits, gain/sum, round and cap.
// Stalls: each stage holds its word while the next one is full and stalled;
// empty stages keep filling, so sample.ready stays high until every stage
// holds a word.
// Reset: empties the pipe and loads every track with the default settings
// (disabled, threshold 80, 4:1, no gain, hard knee, caps 1..127).
module velocity_compressor_limiter import vcl_pkg::*; #(
  parameter int TRACK_COUNT = 4,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  vcl_in_if.sink                 sample,
  vcl_out_if.source              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SET_W-1:0]       cfg_data
);

  localparam int QW     = FRAC_BITS + QUO_INT_W;
  localparam int DS     = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int STAGES = DS + 4;

  // per-stage valid bits; a stage advances when empty or when its successor advances
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] adv;

  always_comb begin
    adv[STAGES-1] = !vld[STAGES-1] || result.ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= (i == 0) ? sample.valid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign sample.ready = adv[0];
  assign result.valid = vld[STAGES-1];

  div_req_t      req;
  logic [QW-1:0] quo;
  item_t         side;

  // settings lookup, field decode, knee product
  vcl_decode #(
    .TRACK_COUNT(TRACK_COUNT)
  ) u_decode (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .en       (adv[1:0]),
    .track    (sample.track),
    .velocity (sample.velocity),
    .req      (req)
  );

  // exact fixed-point quotient, 8 bits per stage
  vcl_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_divider (
    .clk (clk),
    .en  (adv[DS+1:2]),
    .req (req),
    .quo (quo),
    .side(side)
  );

  // makeup gain, rounding, caps; last stage is the output register
  vcl_finish #(
    .FRAC_BITS(FRAC_BITS)
  ) u_finish (
    .clk           (clk),
    .en            (adv[STAGES-1:STAGES-2]),
    .quo           (quo),
    .side          (side),
    .velocity_out  (result.velocity_out),
    .gain_reduction(result.gain_reduction)
  );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the velocity compressor/limiter pipeline.
module tb_top;
  import vcl_pkg::*;

  localparam int TRACKS       = 4;
  localparam int FRACB        = 16;
  localparam int DRAIN_CYCLES = 12;    // pipe has 7 stages, leave some slack
  localparam int HOLD_CYCLES  = 120;   // long result-side stall, fills the pipe
  localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either side
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 280;

  // Scoreboard: per-track settings copy, bit-exact compression predictor and
  // the queue of expected result words in order of acceptance.
  class limiter_scoreboard;
    typedef struct packed {
      logic [VEL_W-1:0] vel;
      logic [VEL_W-1:0] red;
    } out_word_t;

    logic [SET_W-1:0] track_set [REG_COUNT];
    out_word_t        pending[$];
    int               errors;

    function new();
      foreach (track_set[i]) track_set[i] = SETTINGS_RESET;
      errors = 0;
    endfunction

    function void load_setting(logic [CFG_INDEX_W-1:0] idx, logic [SET_W-1:0] val);
      if (idx < REG_COUNT) track_set[idx] = val;
    endfunction

    function longint ratio_value(logic [2:0] code);
      longint r;
      case (code)
        3'd0: r = 1;
        3'd1: r = 2;
        3'd2: r = 3;
        3'd3: r = 4;
        3'd4: r = 6;
        3'd5: r = 8;
        3'd6: r = 10;
        default: r = 1000;
      endcase
      return r;
    endfunction

    function out_word_t compress_word(logic [TRACK_W-1:0] trk, logic [VEL_W-1:0] vel);
      logic [SET_W-1:0] s;
      longint v, t, r, d, num, den, cfix, g, sum, iv, mn, mx, red;
      logic knee_soft;
      out_word_t w;
      // unknown or disabled track: straight through, nothing removed
      if (trk >= TRACKS || trk >= REG_COUNT || !track_set[trk][F_EN_BIT]) begin
        w.vel = vel;
        w.red = '0;
        return w;
      end
      s = track_set[trk];
      t = s[F_THR_LSB +: VEL_W];
      if (t == 0) t = 1;
      r = ratio_value(s[F_RAT_LSB +: 3]);
      g = longint'($signed(s[F_GAIN_LSB +: 7]));
      if (g < -20) g = -20;
      if (g > 40) g = 40;
      knee_soft = s[F_KNEE_BIT];
      mn = s[F_MIN_LSB +: VEL_W];
      if (mn == 0) mn = 1;
      mx = s[F_MAX_LSB +: VEL_W];
      if (mx == 0) mx = 1;
      v = (vel == 0) ? 1 : vel;

      // compressed level, FRACB fraction bits, round half up
      if (v <= t) begin
        cfix = v << FRACB;
      end else begin
        d = v - t;
        if (knee_soft && d < 6) begin
          den = 144 * r;
          num = v * den - (d + 6) * (d + 6) * d * (r - 1);
        end else begin
          den = r;
          num = t * r + d;
        end
        cfix = ((num << (FRACB + 1)) + den) / (2 * den);
      end

      sum = cfix + g * (longint'(1) << FRACB);
      if (sum < 0) sum = 0;
      if (sum > (longint'(127) << FRACB)) sum = longint'(127) << FRACB;
      iv = (sum + (longint'(1) << (FRACB - 1))) >> FRACB;
      if (iv < 1) iv = 1;
      if (iv > 127) iv = 127;
      if (iv < mn) iv = mn;
      if (iv > mx) iv = mx;
      red = ((v << FRACB) - cfix + (longint'(1) << (FRACB - 1))) >> FRACB;

      w.vel = iv[VEL_W-1:0];
      w.red = red[VEL_W-1:0];
      return w;
    endfunction

    function void note_sample(logic [TRACK_W-1:0] trk, logic [VEL_W-1:0] vel);
      pending.push_back(compress_word(trk, vel));
    endfunction

    function void check_result(logic [VEL_W-1:0] vo, logic [VEL_W-1:0] gr);
      out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual vel %0d red %0d",
                 $time, vo, gr);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (vo !== want.vel) begin
        $display("%0t: velocity_out expected %0d actual %0d", $time, want.vel, vo);
        errors++;
      end
      if (gr !== want.red) begin
        $display("%0t: gain_reduction expected %0d actual %0d", $time, want.red, gr);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [SET_W-1:0]       cfg_data;

  // calm: neither side idles; hold_req: ask the result side for a long stall
  bit calm;
  bit hold_req;

  limiter_scoreboard sb = new();

  vcl_in_if  sample_if ();
  vcl_out_if result_if ();

  velocity_compressor_limiter #(
    .TRACK_COUNT (TRACKS),
    .FRAC_BITS   (FRACB)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitors: sample both channels at the edge. Result check goes first so a
  // word accepted this edge is never compared against itself.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_if.valid && result_if.ready)
        sb.check_result(result_if.velocity_out, result_if.gain_reduction);
      if (sample_if.valid && sample_if.ready)
        sb.note_sample(sample_if.track, sample_if.velocity);
    end
  end

  // Result side: random back-pressure, or one long stall on request. The
  // stall is counted here so the sender keeps pushing until the pipe is full
  // and sample.ready drops.
  initial begin : result_side
    bit held;
    held            = 1'b0;
    result_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_if.ready <= !rst && (calm || $urandom_range(99) >= 27);
        @(posedge clk);
      end
    end
  end

  // Watchdog: any word moving on either channel resets the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[velocity_compressor_limiter] ERROR");
    $finish;
  end

  // Offer one sample word, with a random gap before it unless calm. valid is
  // assigned once per step: either lowered for a gap or set for the word.
  task automatic send_sample(logic [TRACK_W-1:0] trk, logic [VEL_W-1:0] vel);
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        sample_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_if.valid    <= 1'b1;
    sample_if.track    <= trk;
    sample_if.velocity <= vel;
    @(posedge clk);
    while (!sample_if.ready) @(posedge clk);
  endtask

  // Stop offering, let every expected word come back, then let the pipe drain.
  task automatic settle();
    sample_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write, with cfg_we lowered again before returning so back-to-back calls never
  // assign cfg_we twice in one step.
  task automatic write_track(logic [CFG_INDEX_W-1:0] idx, logic [SET_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.load_setting(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SET_W-1:0] pack_track(logic en, logic [6:0] thr, logic [2:0] rat,
                                                  logic [6:0] gain, logic knee,
                                                  logic [6:0] vmin, logic [6:0] vmax);
    logic [SET_W-1:0] s;
    s = '0;
    s[F_EN_BIT]          = en;
    s[F_THR_LSB  +: 7]   = thr;
    s[F_RAT_LSB  +: 3]   = rat;
    s[F_GAIN_LSB +: 7]   = gain;
    s[F_KNEE_BIT]        = knee;
    s[F_MIN_LSB  +: 7]   = vmin;
    s[F_MAX_LSB  +: 7]   = vmax;
    return s;
  endfunction

  function automatic logic [SET_W-1:0] random_track();
    logic [SET_W-1:0] s;
    s = {1'($urandom_range(1, 0)), 32'($urandom())};
    s[F_EN_BIT] = ($urandom_range(99) < 85);
    return s;
  endfunction

  initial begin : stimulus
    logic [TRACK_W-1:0] trk;
    logic [VEL_W-1:0]   vel;
    int                 thr;

    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    sample_if.valid    = 1'b0;
    sample_if.track    = '0;
    sample_if.velocity = '0;
    calm               = 1'b0;
    hold_req           = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset every track is disabled: all words pass straight through,
    // also for track numbers past the last register.
    send_sample(8'd0, 7'd127);
    send_sample(8'd255, 7'd0);
    send_sample(8'd4, 7'd64);
    settle();

    // Directed settings:
    //   track 0: plain 4:1 hard knee at 80
    //   track 1: threshold 0 (read as 1), 1000:1, gain -64 (clamps to -20),
    //            soft knee, min and max 0 (read as 1)
    //   track 2: threshold 127, 1:1, gain 63 (clamps to 40), soft, caps 127
    //   track 3: threshold 60, 6:1, gain -5, soft, min 100 above max 50
    // Writes to indexes past the last track must be dropped.
    write_track(3'd0, pack_track(1'b1, 7'd80, 3'd3, 7'h00, 1'b0, 7'd1, 7'd127));
    write_track(3'd1, pack_track(1'b1, 7'd0, 3'd7, 7'h40, 1'b1, 7'd0, 7'd0));
    write_track(3'd2, pack_track(1'b1, 7'd127, 3'd0, 7'h3F, 1'b1, 7'd127, 7'd127));
    write_track(3'd3, pack_track(1'b1, 7'd60, 3'd4, 7'h7B, 1'b1, 7'd100, 7'd50));
    write_track(3'd4, {SET_W{1'b1}});
    write_track(3'd7, '0);

    send_sample(8'd0, 7'd0);    // zero velocity is taken as 1
    send_sample(8'd0, 7'd127);
    send_sample(8'd0, 7'd80);   // right at threshold
    send_sample(8'd0, 7'd81);
    send_sample(8'd1, 7'd0);
    send_sample(8'd1, 7'd1);
    send_sample(8'd1, 7'd2);    // inside the soft knee
    send_sample(8'd1, 7'd127);
    send_sample(8'd2, 7'd127);
    send_sample(8'd2, 7'd126);
    send_sample(8'd3, 7'd60);   // soft knee: at threshold keeps the early return
    send_sample(8'd3, 7'd61);
    send_sample(8'd3, 7'd63);
    send_sample(8'd3, 7'd65);   // last step inside the knee
    send_sample(8'd3, 7'd66);   // first step above the knee
    send_sample(8'd3, 7'd127);
    send_sample(8'd4, 7'd10);
    send_sample(8'd200, 7'd127);
    settle();

    // Random phases. Phase 0 drives the register extremes: all ones on two
    // tracks, enable alone on the other two. Phase 2 runs with no idling and
    // one long result stall so the pipe fills and stalls its input.
    for (int ph = 0; ph < PHASES; ph++) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        if (ph == 0)
          write_track(CFG_INDEX_W'(i), (i < 2) ? {SET_W{1'b1}} : SET_W'(1));
        else
          write_track(CFG_INDEX_W'(i), random_track());
      end
      if (ph == 2) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99) < 85)
          trk = TRACK_W'($urandom_range(TRACKS - 1, 0));
        else
          trk = TRACK_W'($urandom_range(255, TRACKS));
        // a third of the words on tracks with a register sit just at or above threshold, to hit the knee
        if (trk < REG_COUNT && $urandom_range(99) < 33) begin
          thr = sb.track_set[trk][F_THR_LSB +: VEL_W];
          thr = thr + $urandom_range(7, 0);
          vel = (thr > 127) ? 7'd127 : VEL_W'(thr);
        end else begin
          vel = VEL_W'($urandom_range(127, 0));
        end
        send_sample(trk, vel);
      end
      settle();
      calm = 1'b0;
    end

    if (sb.errors == 0)
      $display("[velocity_compressor_limiter] OK");
    else
      $display("[velocity_compressor_limiter] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/vcl_pkg.sv
src/vcl_in_if.sv
src/vcl_out_if.sv
src/vcl_decode.sv
src/vcl_divider.sv
src/vcl_finish.sv
src/velocity_compressor_limiter.sv
test/tb_top.sv
